// ----- rtl/button_press_classifier_top_macros.svh -----
// Assertion macros for the button press classifier.
// Simulation builds get the checking form; synthesis builds get empty bodies.
`ifndef BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Checked at every clock edge outside of reset.
`define BPC_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
// Checked at every clock edge, reset included.
`define BPC_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define BPC_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BPC_ASSERT_ALWAYS(lbl, clk_s, prop, msg)
`endif
`endif

// ----- rtl/bpc_pkg.sv -----
package bpc_pkg;

  // Default number of buttons with state entries.
  localparam int NUM_BUTTONS_DEF = 8;

  // Configuration port.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_NORMAL_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTONS_USED = 2'd2;

  // Register reset values.
  localparam logic [15:0] NORMAL_PRESS_RST = 16'd50;
  localparam logic [15:0] LONG_PRESS_RST   = 16'd1000;
  localparam logic [3:0]  BUTTONS_USED_RST = 4'd8;

  // Per-button phase codes.
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_PRESSED = 2'd1;
  localparam logic [1:0] PH_WAIT    = 2'd2;

  // Sampled level codes.
  localparam logic [1:0] LVL_INACTIVE = 2'd0;
  localparam logic [1:0] LVL_ACTIVE   = 2'd1;

  // Event codes.
  localparam logic [1:0] EV_PRESSED  = 2'd0;
  localparam logic [1:0] EV_LONG     = 2'd1;
  localparam logic [1:0] EV_NORMAL   = 2'd2;
  localparam logic [1:0] EV_RELEASED = 2'd3;

  // Input word: one sample of one button.
  typedef struct packed {
    logic [2:0]  button;
    logic [1:0]  level;
    logic [31:0] now_ms;
  } in_word_t;

  // Output word: one event.
  typedef struct packed {
    logic [2:0] button_id;
    logic [1:0] event_res;
    logic       last;
  } out_word_t;

  // State entry kept per button in the state memory.
  typedef struct packed {
    logic [1:0]  phase;
    logic [31:0] start_time;
  } entry_t;

endpackage

// ----- rtl/button_press_classifier_top.sv -----
// Button press classifier.
// The input channel (in_valid, in_ready, in_data) carries one word per sample:
// a button index, its level (inactive, active or unknown) and a wrapping
// millisecond timestamp. The output channel (out_valid, out_ready, out_data)
// carries event words: button, event code and a last flag on the final event
// of a sample. A sample raises zero, one or two events.
// An accepted sample waits in the stage-one register, and its events enter
// the output queue when it leaves that stage, which it does once there is room.
// The block takes one sample per cycle while the queue has room. The per-button
// state sits in a small RAM with a registered read; a sample reads its entry on
// acceptance and writes it back as it leaves stage one, with a bypass register
// covering a sample for the same button that follows directly. The output
// side drains one word per cycle while out_ready is high.
// Events wait in a four-word queue; when out_ready is low the queue fills and
// the pending sample holds in_ready low until there is room for its events.
// Reset (rst, synchronous) sets every button idle with a start time of zero,
// empties the queue and loads the default register values. Configuration writes
// (cfg_we, cfg_index, cfg_data) take effect at once and must only be made
// while no sample is in flight.
`include "button_press_classifier_top_macros.svh"

module button_press_classifier_top #(
  parameter int NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bpc_pkg::in_word_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output bpc_pkg::out_word_t                  out_data,
  input  logic                                cfg_we,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data
);

  import bpc_pkg::*;

  localparam int ADDR_W   = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;
  localparam int OQ_DEPTH = 4;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_CNT_W = OQ_PTR_W + 1;

  // Configuration registers.
  logic [15:0] normal_press_ms;
  logic [15:0] long_press_ms;
  logic [3:0]  buttons_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_press_ms <= NORMAL_PRESS_RST;
      long_press_ms   <= LONG_PRESS_RST;
      buttons_in_use  <= BUTTONS_USED_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_NORMAL_PRESS: normal_press_ms <= cfg_data;
        CFG_LONG_PRESS:   long_press_ms   <= cfg_data;
        CFG_BUTTONS_USED: buttons_in_use  <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Handshake and pipeline control.
  logic                    in_fire;
  logic                    s1_valid;
  logic                    s1_go;
  in_word_t                s1_word;
  logic [ADDR_W-1:0]       in_addr;
  logic [ADDR_W-1:0]       s1_addr;
  logic [6:0]              in_btn_ext;
  logic [6:0]              s1_btn_ext;

  assign in_fire    = in_valid && in_ready;
  assign in_ready   = !s1_valid || s1_go;
  assign in_btn_ext = {4'b0, in_data.button};
  assign s1_btn_ext = {4'b0, s1_word.button};
  assign in_addr    = in_btn_ext[ADDR_W-1:0];
  assign s1_addr    = s1_btn_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word <= in_data;
    end
  end

  // State memory, valid bits and write-back bypass.
  logic                    ram_we;
  entry_t                  ram_rdata;
  entry_t                  entry_next;
  logic [NUM_BUTTONS-1:0]  entry_valid;
  logic                    fwd_hit;
  entry_t                  fwd_entry;
  entry_t                  cur;

  bpc_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (NUM_BUTTONS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (entry_next),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
    end else if (ram_we) begin
      entry_valid[s1_addr] <= 1'b1;
    end
  end

  // A sample for the button being written back gets the new entry directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (in_fire) begin
      fwd_hit <= ram_we && (s1_addr == in_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      fwd_entry <= entry_next;
    end
  end

  // Entries never written read as idle with a zero start time.
  always_comb begin
    if (fwd_hit) begin
      cur = fwd_entry;
    end else if (entry_valid[s1_addr]) begin
      cur = ram_rdata;
    end else begin
      cur = '0;
    end
  end

  // Phase update and event selection for the sample in stage one.
  logic        s1_ignore;
  logic        active;
  logic [31:0] elapsed;
  logic        long_hit;
  logic        normal_hit;
  logic [1:0]  ev_n;
  logic [1:0]  ev0;
  logic [1:0]  ev1;

  assign active     = (s1_word.level == LVL_ACTIVE);
  assign s1_ignore  = ((s1_word.level != LVL_ACTIVE) && (s1_word.level != LVL_INACTIVE)) ||
                      ({1'b0, s1_word.button} >= buttons_in_use) ||
                      (s1_btn_ext >= 7'(NUM_BUTTONS));
  assign elapsed    = s1_word.now_ms - cur.start_time;
  assign long_hit   = elapsed > {16'b0, long_press_ms};
  assign normal_hit = elapsed > {16'b0, normal_press_ms};

  always_comb begin
    ev_n       = 2'd0;
    ev0        = EV_PRESSED;
    ev1        = EV_RELEASED;
    entry_next = cur;
    unique case (cur.phase)
      PH_PRESSED: begin
        if (active) begin
          if (long_hit) begin
            ev_n                  = 2'd1;
            ev0                   = EV_LONG;
            entry_next.phase      = PH_WAIT;
            entry_next.start_time = s1_word.now_ms;
          end
        end else if (normal_hit) begin
          // Normal press falls through to its release in the same sample.
          ev_n             = 2'd2;
          ev0              = EV_NORMAL;
          ev1              = EV_RELEASED;
          entry_next.phase = PH_IDLE;
        end else begin
          entry_next.phase = PH_IDLE;
        end
      end
      PH_WAIT: begin
        if (!active) begin
          ev_n             = 2'd1;
          ev0              = EV_RELEASED;
          entry_next.phase = PH_IDLE;
        end else if (long_hit) begin
          ev_n                  = 2'd1;
          ev0                   = EV_LONG;
          entry_next.start_time = s1_word.now_ms;
        end
      end
      default: begin
        // Idle, and the unused phase code, which behaves as idle.
        entry_next.phase = PH_IDLE;
        if (active) begin
          ev_n                  = 2'd1;
          ev0                   = EV_PRESSED;
          entry_next.phase      = PH_PRESSED;
          entry_next.start_time = s1_word.now_ms;
        end
      end
    endcase
    if (s1_ignore) begin
      ev_n = 2'd0;
    end
  end

  // Output queue of event words.
  out_word_t             oq [OQ_DEPTH];
  logic [OQ_PTR_W-1:0]   oq_wr;
  logic [OQ_PTR_W-1:0]   oq_rd;
  logic [OQ_CNT_W-1:0]   oq_count;
  logic [OQ_CNT_W:0]     oq_need;
  logic [1:0]            push_n;
  logic                  pop;
  out_word_t             word0;
  out_word_t             word1;

  assign oq_need = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(ev_n);
  assign s1_go   = s1_valid && (oq_need <= (OQ_CNT_W + 1)'(OQ_DEPTH));
  assign ram_we  = s1_go && !s1_ignore;
  assign push_n  = s1_go ? ev_n : 2'd0;
  assign pop     = out_valid && out_ready;

  assign word0 = '{button_id: s1_word.button, event_res: ev0, last: (ev_n == 2'd1)};
  assign word1 = '{button_id: s1_word.button, event_res: ev1, last: 1'b1};

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      oq[oq_wr] <= word0;
    end
    if (push_n == 2'd2) begin
      oq[oq_wr + OQ_PTR_W'(1)] <= word1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      oq_wr    <= '0;
      oq_rd    <= '0;
      oq_count <= '0;
    end else begin
      oq_wr    <= oq_wr + OQ_PTR_W'(push_n);
      oq_rd    <= oq_rd + OQ_PTR_W'(pop);
      oq_count <= oq_count + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
    end
  end

  assign out_valid = (oq_count != '0);
  assign out_data  = oq[oq_rd];

  // Checks.
  `BPC_ASSERT(a_oq_bound, clk, rst, oq_count <= OQ_CNT_W'(OQ_DEPTH), "output queue overflow")
  `BPC_ASSERT(a_fwd_src, clk, rst, $past(in_fire) && fwd_hit |-> $past(ram_we), "bypass without write-back")
  `BPC_ASSERT(a_s1_hold, clk, rst, s1_valid && !s1_go |=> s1_valid && $stable(s1_word), "stalled sample lost")
  `BPC_ASSERT(a_accept_s1, clk, rst, in_fire |=> s1_valid, "accepted sample not staged")
  `BPC_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> oq_count == '0, "queue not empty after reset")

endmodule

// ----- rtl/bpc_ram.sv -----
module bpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
